@@ hw/rtl/c_source_reformatter_unit_defines.svh @@
// assertion macros for the c source reformatter unit
// no dependencies; included by files that carry concurrent assertions
`ifndef C_SOURCE_REFORMATTER_UNIT_DEFINES_SVH
`define C_SOURCE_REFORMATTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define CRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRF_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CRF_ASSERT(label, clk, rst_n, prop, msg)
`define CRF_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/crf_pkg.sv @@
// shared types, constants and helper functions of the c source reformatter
// no dependencies
package crf_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int DEPTH_W = 6;
    localparam int RUN_SLOTS = 5;
    localparam int SLOT_W = 3;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        REG_INDENT_WIDTH = 2'd0,
        REG_USE_TAB      = 2'd1,
        REG_BRACE_NL     = 2'd2,
        REG_PAD_OPS      = 2'd3
    } crf_reg_t;

    typedef struct packed {
        logic [3:0] indent_width;
        logic       use_tab_indent;
        logic       brace_on_new_line;
        logic       pad_operators;
    } crf_cfg_t;

    typedef struct packed {
        logic               in_string_lit;
        logic               in_char_lit;
        logic               in_line_comment;
        logic               in_directive;
        logic [7:0]         prev_byte;
        logic [DEPTH_W-1:0] brace_depth;
    } crf_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [8:0] repeat_count;
    } crf_run_t;

    typedef struct packed {
        crf_run_t [RUN_SLOTS-1:0] runs;
        logic [SLOT_W-1:0]        num;
    } crf_plan_t;

    function automatic logic is_op(logic [7:0] b);
        logic r;
        case (b)
            CHAR_NUL, 8'h3D, 8'h2B, 8'h2D, 8'h2A, CHAR_SLASH, 8'h25,
            8'h3C, 8'h3E, 8'h21, 8'h26, 8'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] indent_run(logic [DEPTH_W-1:0] depth, crf_cfg_t cfg);
        logic [3:0] per;
        logic [DEPTH_W+3:0] prod;
        per = cfg.use_tab_indent ? 4'd1 : cfg.indent_width;
        prod = (DEPTH_W+4)'(depth) * (DEPTH_W+4)'(per);
        return (prod > (DEPTH_W+4)'(256)) ? 9'd256 : prod[8:0];
    endfunction

endpackage

@@ hw/rtl/c_source_reformatter_unit.sv @@
// top level of the c source reformatter: apb registers, state, run queue, output register
// depends on crf_pkg, crf_planner and c_source_reformatter_unit_defines.svh
//
// Each accepted source byte yields one to five (byte, repeat) runs, delivered one run per
// cycle while the output is not stalled by m_ready, from a five-entry run queue through a
// single output register. The next byte is taken in the cycle its predecessor's final run
// moves to the output register, so one-run bytes stream at one per cycle without stalls.
`include "c_source_reformatter_unit_defines.svh"

module c_source_reformatter_unit import crf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_cur_byte,
    input  logic [7:0]  s_next_byte,
    input  logic        s_start_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [8:0]  m_repeat_count,
    output logic        m_last
);

    crf_cfg_t                 cfg_reg;
    crf_state_t               state_reg;
    crf_state_t               state_next;
    crf_plan_t                plan;
    crf_run_t [RUN_SLOTS-1:0] job_runs_reg;
    logic [SLOT_W-1:0]        job_cnt_reg;
    logic                     m_valid_reg;
    crf_run_t                 m_run_reg;
    logic                     m_last_reg;
    logic                     out_free;
    logic                     take;
    logic                     s_xfer;
    logic                     cfg_wr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{indent_width: 4'd4, use_tab_indent: 1'b0,
                         brace_on_new_line: 1'b0, pad_operators: 1'b1};
        end else if (cfg_wr) begin
            unique case (crf_reg_t'(paddr[3:2]))
                REG_INDENT_WIDTH: cfg_reg.indent_width <= pwdata[3:0];
                REG_USE_TAB:      cfg_reg.use_tab_indent <= pwdata[0];
                REG_BRACE_NL:     cfg_reg.brace_on_new_line <= pwdata[0];
                REG_PAD_OPS:      cfg_reg.pad_operators <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (crf_reg_t'(paddr[3:2]))
            REG_INDENT_WIDTH: prdata = {28'd0, cfg_reg.indent_width};
            REG_USE_TAB:      prdata = {31'd0, cfg_reg.use_tab_indent};
            REG_BRACE_NL:     prdata = {31'd0, cfg_reg.brace_on_new_line};
            REG_PAD_OPS:      prdata = {31'd0, cfg_reg.pad_operators};
            default:          prdata = '0;
        endcase
    end

    crf_planner u_planner (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .cur_byte      (s_cur_byte),
        .next_byte     (s_next_byte),
        .start_of_text (s_start_of_text),
        .state_next    (state_next),
        .plan          (plan)
    );

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign take = (job_cnt_reg != '0) && out_free;
    assign s_ready = (job_cnt_reg == '0) || ((job_cnt_reg == SLOT_W'(1)) && out_free);
    assign s_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // run queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_cnt_reg <= '0;
        end else if (s_xfer) begin
            job_cnt_reg <= plan.num;
        end else if (take) begin
            job_cnt_reg <= job_cnt_reg - SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            job_runs_reg <= plan.runs;
        end else if (take) begin
            for (int i = 0; i < RUN_SLOTS - 1; i++) begin
                job_runs_reg[i] <= job_runs_reg[i+1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_run_reg <= job_runs_reg[0];
            m_last_reg <= (job_cnt_reg == SLOT_W'(1));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = m_run_reg.out_byte;
    assign m_repeat_count = m_run_reg.repeat_count;
    assign m_last = m_last_reg;

    `CRF_ASSERT(a_queue_bound, aclk, aresetn, job_cnt_reg <= SLOT_W'(RUN_SLOTS), "run queue overflow")
    `CRF_ASSERT(a_accept_drained, aclk, aresetn, s_xfer |-> job_cnt_reg <= SLOT_W'(1), "byte taken over pending runs")
    `CRF_ASSERT(a_accept_loads, aclk, aresetn, s_xfer |=> job_cnt_reg != '0, "byte produced no runs")
    `CRF_ASSERT(a_depth_bound, aclk, aresetn, state_reg.brace_depth <= DEPTH_W'(MAX_DEPTH), "brace depth past limit")
    `CRF_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid_reg && job_cnt_reg == '0, "not idle after reset")

endmodule

@@ hw/rtl/crf_planner.sv @@
// per-byte mode tracking and run list planning
// depends on crf_pkg
module crf_planner import crf_pkg::*; (
    input  crf_cfg_t   cfg,
    input  crf_state_t state,
    input  logic [7:0] cur_byte,
    input  logic [7:0] next_byte,
    input  logic       start_of_text,
    output crf_state_t state_next,
    output crf_plan_t  plan
);

    crf_state_t         st;
    logic               line_start;
    logic               in_text;
    logic               pad;
    logic [7:0]         ind_char;
    logic [8:0]         ind_old;
    logic [8:0]         ind_new;
    logic [DEPTH_W-1:0] depth_new;

    always_comb begin
        st = start_of_text ? '0 : state;
        line_start = start_of_text || (st.prev_byte == CHAR_NL);

        if (cur_byte == CHAR_DQUOTE && !st.in_char_lit && !st.in_line_comment) begin
            if (!st.in_string_lit || st.prev_byte != CHAR_BSLASH) begin
                st.in_string_lit = !st.in_string_lit;
            end
        end
        if (cur_byte == CHAR_SQUOTE && !st.in_string_lit && !st.in_line_comment) begin
            if (!st.in_char_lit || st.prev_byte != CHAR_BSLASH) begin
                st.in_char_lit = !st.in_char_lit;
            end
        end
        if (!st.in_string_lit && !st.in_char_lit) begin
            if (cur_byte == CHAR_SLASH && next_byte == CHAR_SLASH) begin
                st.in_line_comment = 1'b1;
            end
            if (cur_byte == CHAR_NL) begin
                st.in_line_comment = 1'b0;
            end
        end
        if (cur_byte == CHAR_HASH && line_start) begin
            st.in_directive = 1'b1;
        end
        if (cur_byte == CHAR_NL) begin
            st.in_directive = 1'b0;
        end

        in_text = !st.in_string_lit && !st.in_char_lit && !st.in_line_comment;
        depth_new = st.brace_depth;
        if (in_text && cur_byte == CHAR_LBRACE && st.brace_depth < DEPTH_W'(MAX_DEPTH)) begin
            depth_new = st.brace_depth + DEPTH_W'(1);
        end
        if (in_text && cur_byte == CHAR_RBRACE && st.brace_depth != '0) begin
            depth_new = st.brace_depth - DEPTH_W'(1);
        end

        ind_char = cfg.use_tab_indent ? CHAR_TAB : CHAR_SPACE;
        ind_old = indent_run(st.brace_depth, cfg);
        ind_new = indent_run(depth_new, cfg);
        pad = cfg.pad_operators && is_op(cur_byte);

        plan = '0;
        if (!in_text) begin
            plan.runs[0] = '{cur_byte, 9'd1};
            plan.num = SLOT_W'(1);
        end else if (cur_byte == CHAR_LBRACE) begin
            if (!cfg.brace_on_new_line) begin
                plan.runs[plan.num] = '{CHAR_SPACE, 9'd1};
                plan.num = plan.num + SLOT_W'(1);
            end else begin
                plan.runs[plan.num] = '{CHAR_NL, 9'd1};
                plan.num = plan.num + SLOT_W'(1);
                if (ind_old != '0) begin
                    plan.runs[plan.num] = '{ind_char, ind_old};
                    plan.num = plan.num + SLOT_W'(1);
                end
            end
            plan.runs[plan.num] = '{cur_byte, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
            plan.runs[plan.num] = '{CHAR_NL, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
            if (ind_new != '0) begin
                plan.runs[plan.num] = '{ind_char, ind_new};
                plan.num = plan.num + SLOT_W'(1);
            end
        end else if (cur_byte == CHAR_RBRACE) begin
            plan.runs[plan.num] = '{CHAR_NL, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
            if (ind_new != '0) begin
                plan.runs[plan.num] = '{ind_char, ind_new};
                plan.num = plan.num + SLOT_W'(1);
            end
            plan.runs[plan.num] = '{cur_byte, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
        end else if (cur_byte == CHAR_SEMI) begin
            plan.runs[plan.num] = '{cur_byte, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
            if (!st.in_directive) begin
                plan.runs[plan.num] = '{CHAR_NL, 9'd1};
                plan.num = plan.num + SLOT_W'(1);
                if (ind_new != '0) begin
                    plan.runs[plan.num] = '{ind_char, ind_new};
                    plan.num = plan.num + SLOT_W'(1);
                end
            end
        end else begin
            if (pad && !is_op(st.prev_byte)) begin
                plan.runs[plan.num] = '{CHAR_SPACE, 9'd1};
                plan.num = plan.num + SLOT_W'(1);
            end
            plan.runs[plan.num] = '{cur_byte, 9'd1};
            plan.num = plan.num + SLOT_W'(1);
            if (pad && !is_op(next_byte)) begin
                plan.runs[plan.num] = '{CHAR_SPACE, 9'd1};
                plan.num = plan.num + SLOT_W'(1);
            end
        end

        state_next = st;
        state_next.brace_depth = depth_new;
        state_next.prev_byte = cur_byte;
    end

endmodule
